/* src/weekly_alarm_event_table_top_assert.svh */
// assertion macros used by the weekly alarm event table datapath
// expects clk and arst_n in scope at the point of use
`ifndef WEEKLY_ALARM_EVENT_TABLE_TOP_ASSERT_SVH
`define WEEKLY_ALARM_EVENT_TABLE_TOP_ASSERT_SVH

// same-cycle implication
`define WAET_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("weekly alarm table check failed");

// next-cycle implication
`define WAET_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("weekly alarm table check failed");

`endif

/* src/waet_pkg.sv */
// shared types and codes of the weekly alarm event table
// no dependencies
package waet_pkg;

	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_DELETE = 2'd1;
	localparam logic [1:0] CMD_TICK   = 2'd2;

	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_ON     = 2'd1;
	localparam logic [1:0] KIND_OFF    = 2'd2;
	localparam logic [1:0] KIND_DONE   = 2'd3;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;
	localparam logic [1:0] STAT_RANGE = 2'd3;

	typedef struct packed {
		logic [4:0] start_hour;
		logic [5:0] start_minute;
		logic [4:0] end_hour;
		logic [5:0] end_minute;
		logic [6:0] weekday_mask;
		logic       active;
	} entry_t;

	typedef struct packed {
		logic       load_in;
		logic       wr_add;
		logic       cnt_inc;
		logic       cnt_dec;
		logic       ptr_load_idx;
		logic       ptr_clear;
		logic       ptr_inc;
		logic       rd_next;
		logic       rd_cur;
		logic       wr_shift;
		logic       wr_tick;
		logic       emit;
		logic [1:0] emit_kind;
		logic [1:0] emit_status;
		logic       emit_slot;
		logic       emit_last;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       full;
		logic       empty;
		logic       idx_bad;
		logic       more_shift;
		logic       more_scan;
		logic       hit_on;
		logic       hit_off;
		logic       off_pend;
		logic       out_free;
	} dp_stat_t;

endpackage

/* src/waet_dp.sv */
// datapath: event memory, count, scan pointer, input latch and result register
// depends on waet_pkg and weekly_alarm_event_table_top_assert.svh
`include "weekly_alarm_event_table_top_assert.svh"

module waet_dp #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  waet_pkg::dp_cmd_t  cmd_i,
	output waet_pkg::dp_stat_t stat_o,
	input  logic [1:0]         command,
	input  logic [4:0]         start_hour,
	input  logic [5:0]         start_minute,
	input  logic [4:0]         end_hour,
	input  logic [5:0]         end_minute,
	input  logic [6:0]         weekday_mask,
	input  logic [3:0]         delete_index,
	input  logic [4:0]         now_hour,
	input  logic [5:0]         now_minute,
	input  logic [6:0]         now_day_mask,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         kind,
	output logic [1:0]         status,
	output logic [3:0]         slot,
	output logic               last
);

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

	waet_pkg::entry_t mem_q [TABLE_DEPTH];
	waet_pkg::entry_t rd_data_q;
	waet_pkg::entry_t new_q;
	waet_pkg::entry_t wr_data;

	logic [1:0]       cmd_q;
	logic [3:0]       idx_q;
	logic [4:0]       now_hour_q;
	logic [5:0]       now_minute_q;
	logic [6:0]       now_day_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] ptr_q;
	logic [CNT_W:0]   ptr_plus;
	logic [CMP_W-1:0] ptr_ext;
	logic [CMP_W-1:0] idx_ext;
	logic [CMP_W-1:0] count_ext;
	logic             off_q;

	logic             out_valid_q;
	logic [1:0]       kind_q;
	logic [1:0]       status_q;
	logic [3:0]       slot_q;
	logic             last_q;

	logic             start_eq;
	logic             end_eq;
	logic             hit_on;
	logic             act_mid;
	logic             hit_off;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [IDX_W-1:0] rd_addr;

	assign ptr_plus  = {1'b0, ptr_q} + 1'b1;
	assign ptr_ext   = CMP_W'(ptr_q);
	assign idx_ext   = CMP_W'(idx_q);
	assign count_ext = CMP_W'(count_q);

	// entry evaluation against the latched time
	assign start_eq = (rd_data_q.start_hour == now_hour_q) &&
		(rd_data_q.start_minute == now_minute_q);
	assign end_eq   = (rd_data_q.end_hour == now_hour_q) &&
		(rd_data_q.end_minute == now_minute_q);
	assign hit_on   = start_eq && ((rd_data_q.weekday_mask & now_day_q) != 7'd0) &&
		!rd_data_q.active;
	assign act_mid  = rd_data_q.active | hit_on;
	assign hit_off  = end_eq && act_mid;

	assign stat_o.cmd        = cmd_q;
	assign stat_o.full       = (count_q >= CNT_W'(TABLE_DEPTH));
	assign stat_o.empty      = (count_q == '0);
	assign stat_o.idx_bad    = (idx_ext >= count_ext);
	assign stat_o.more_shift = (ptr_plus < {1'b0, count_q});
	assign stat_o.more_scan  = (ptr_q < count_q);
	assign stat_o.hit_on     = hit_on;
	assign stat_o.hit_off    = hit_off;
	assign stat_o.off_pend   = off_q;
	assign stat_o.out_free   = !out_valid_q || !out_stall;

	// memory port selection
	always_comb begin
		wr_en   = cmd_i.wr_add | cmd_i.wr_shift | cmd_i.wr_tick;
		wr_addr = cmd_i.wr_add ? count_q[IDX_W-1:0] : ptr_q[IDX_W-1:0];
		rd_addr = cmd_i.rd_next ? ptr_plus[IDX_W-1:0] : ptr_q[IDX_W-1:0];
		wr_data = rd_data_q;
		if (cmd_i.wr_add) begin
			wr_data = new_q;
		end else if (cmd_i.wr_tick) begin
			wr_data.active = act_mid & ~hit_off;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (cmd_i.rd_next || cmd_i.rd_cur) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// input latch
	always_ff @(posedge clk) begin
		if (cmd_i.load_in) begin
			cmd_q               <= command;
			new_q.start_hour    <= start_hour;
			new_q.start_minute  <= start_minute;
			new_q.end_hour      <= end_hour;
			new_q.end_minute    <= end_minute;
			new_q.weekday_mask  <= weekday_mask;
			new_q.active        <= 1'b0;
			idx_q               <= delete_index;
			now_hour_q          <= now_hour;
			now_minute_q        <= now_minute;
			now_day_q           <= now_day_mask;
		end
		if (cmd_i.wr_tick) begin
			off_q <= hit_off;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ptr_q   <= '0;
		end else begin
			if (cmd_i.cnt_inc) begin
				count_q <= count_q + 1'b1;
			end else if (cmd_i.cnt_dec) begin
				count_q <= count_q - 1'b1;
			end
			if (cmd_i.ptr_clear) begin
				ptr_q <= '0;
			end else if (cmd_i.ptr_load_idx) begin
				ptr_q <= CNT_W'(idx_q);
			end else if (cmd_i.ptr_inc) begin
				ptr_q <= ptr_plus[CNT_W-1:0];
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd_i.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_i.emit) begin
			kind_q   <= cmd_i.emit_kind;
			status_q <= cmd_i.emit_status;
			slot_q   <= cmd_i.emit_slot ? ptr_ext[3:0] : 4'd0;
			last_q   <= cmd_i.emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign status    = status_q;
	assign slot      = slot_q;
	assign last      = last_q;

	`WAET_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_W'(TABLE_DEPTH))
	`WAET_ASSERT_IMP(a_emit_free, cmd_i.emit, !out_valid_q || !out_stall)
	`WAET_ASSERT_IMP(a_write_in_use, cmd_i.wr_shift || cmd_i.wr_tick, ptr_q < count_q)
	`WAET_ASSERT_NXT(a_dec_step, cmd_i.cnt_dec, count_q == $past(count_q) - 1'b1)

endmodule

/* src/waet_ctrl.sv */
// controller: command sequencing for add, delete shift and tick scan
// depends on waet_pkg
module waet_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  waet_pkg::dp_stat_t stat_i,
	output waet_pkg::dp_cmd_t  cmd_o
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_DEL_RD,
		ST_DEL_WR,
		ST_TICK_RD,
		ST_TICK_EVAL,
		ST_TICK_ON,
		ST_TICK_OFF,
		ST_EMIT_STATUS,
		ST_EMIT_DONE
	} state_t;

	state_t     state_q;
	state_t     state_n;
	logic [1:0] code_q;
	logic [1:0] code_n;
	logic       code_set;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd_o    = '0;
		state_n  = state_q;
		code_n   = waet_pkg::STAT_OK;
		code_set = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd_o.load_in = 1'b1;
					state_n       = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (stat_i.cmd)
					waet_pkg::CMD_ADD: begin
						code_set = 1'b1;
						state_n  = ST_EMIT_STATUS;
						if (stat_i.full) begin
							code_n = waet_pkg::STAT_FULL;
						end else begin
							cmd_o.wr_add  = 1'b1;
							cmd_o.cnt_inc = 1'b1;
						end
					end
					waet_pkg::CMD_DELETE: begin
						if (stat_i.empty) begin
							code_set = 1'b1;
							code_n   = waet_pkg::STAT_EMPTY;
							state_n  = ST_EMIT_STATUS;
						end else if (stat_i.idx_bad) begin
							code_set = 1'b1;
							code_n   = waet_pkg::STAT_RANGE;
							state_n  = ST_EMIT_STATUS;
						end else begin
							cmd_o.ptr_load_idx = 1'b1;
							state_n            = ST_DEL_RD;
						end
					end
					waet_pkg::CMD_TICK: begin
						cmd_o.ptr_clear = 1'b1;
						state_n         = ST_TICK_RD;
					end
					default: begin
						state_n = ST_IDLE;
					end
				endcase
			end
			ST_DEL_RD: begin
				if (stat_i.more_shift) begin
					cmd_o.rd_next = 1'b1;
					state_n       = ST_DEL_WR;
				end else begin
					cmd_o.cnt_dec = 1'b1;
					code_set      = 1'b1;
					state_n       = ST_EMIT_STATUS;
				end
			end
			ST_DEL_WR: begin
				cmd_o.wr_shift = 1'b1;
				cmd_o.ptr_inc  = 1'b1;
				state_n        = ST_DEL_RD;
			end
			ST_TICK_RD: begin
				if (stat_i.more_scan) begin
					cmd_o.rd_cur = 1'b1;
					state_n      = ST_TICK_EVAL;
				end else begin
					state_n = ST_EMIT_DONE;
				end
			end
			ST_TICK_EVAL: begin
				cmd_o.wr_tick = 1'b1;
				if (stat_i.hit_on) begin
					state_n = ST_TICK_ON;
				end else if (stat_i.hit_off) begin
					state_n = ST_TICK_OFF;
				end else begin
					cmd_o.ptr_inc = 1'b1;
					state_n       = ST_TICK_RD;
				end
			end
			ST_TICK_ON: begin
				if (stat_i.out_free) begin
					cmd_o.emit      = 1'b1;
					cmd_o.emit_kind = waet_pkg::KIND_ON;
					cmd_o.emit_slot = 1'b1;
					if (stat_i.off_pend) begin
						state_n = ST_TICK_OFF;
					end else begin
						cmd_o.ptr_inc = 1'b1;
						state_n       = ST_TICK_RD;
					end
				end
			end
			ST_TICK_OFF: begin
				if (stat_i.out_free) begin
					cmd_o.emit      = 1'b1;
					cmd_o.emit_kind = waet_pkg::KIND_OFF;
					cmd_o.emit_slot = 1'b1;
					cmd_o.ptr_inc   = 1'b1;
					state_n         = ST_TICK_RD;
				end
			end
			ST_EMIT_STATUS: begin
				if (stat_i.out_free) begin
					cmd_o.emit        = 1'b1;
					cmd_o.emit_kind   = waet_pkg::KIND_STATUS;
					cmd_o.emit_status = code_q;
					cmd_o.emit_last   = 1'b1;
					state_n           = ST_IDLE;
				end
			end
			ST_EMIT_DONE: begin
				if (stat_i.out_free) begin
					cmd_o.emit      = 1'b1;
					cmd_o.emit_kind = waet_pkg::KIND_DONE;
					cmd_o.emit_last = 1'b1;
					state_n         = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			code_q  <= waet_pkg::STAT_OK;
		end else begin
			state_q <= state_n;
			if (code_set) begin
				code_q <= code_n;
			end
		end
	end

endmodule

/* src/weekly_alarm_event_table_top.sv */
// Weekly alarm event table. Holds up to TABLE_DEPTH events in a single-port
// memory with registered read; add appends, delete closes the gap, tick scans
// from slot 0 and reports switch-on and switch-off results, then a finish
// result. One item is worked on at a time. Delete takes a memory read and a
// write-back through the one memory port for each entry shifted down, and tick
// does so for each stored entry, with an emit state for each on or off result.
// The next item is taken while the last result still waits in the output
// register. No clearing pass.
// depends on waet_pkg, waet_ctrl and waet_dp
module weekly_alarm_event_table_top #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] command,
	input  logic [4:0] start_hour,
	input  logic [5:0] start_minute,
	input  logic [4:0] end_hour,
	input  logic [5:0] end_minute,
	input  logic [6:0] weekday_mask,
	input  logic [3:0] delete_index,
	input  logic [4:0] now_hour,
	input  logic [5:0] now_minute,
	input  logic [6:0] now_day_mask,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] kind,
	output logic [1:0] status,
	output logic [3:0] slot,
	output logic       last
);

	waet_pkg::dp_cmd_t  dp_cmd;
	waet_pkg::dp_stat_t dp_stat;

	waet_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat_i   (dp_stat),
		.cmd_o    (dp_cmd)
	);

	waet_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_i        (dp_cmd),
		.stat_o       (dp_stat),
		.command      (command),
		.start_hour   (start_hour),
		.start_minute (start_minute),
		.end_hour     (end_hour),
		.end_minute   (end_minute),
		.weekday_mask (weekday_mask),
		.delete_index (delete_index),
		.now_hour     (now_hour),
		.now_minute   (now_minute),
		.now_day_mask (now_day_mask),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.status       (status),
		.slot         (slot),
		.last         (last)
	);

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// testbench for weekly_alarm_event_table_top: directed and random add, delete and tick items,
// every result checked against an in-bench model of the event table
// depends on waet_pkg and the weekly_alarm_event_table_top rtl
module testbench;

	localparam int TABLE_DEPTH = 16;
	localparam int SETTLE_CYCLES = 80;
	localparam int HOLD_CYCLES = 400;
	localparam logic [1:0] CMD_NONE = 2'd3;

	typedef struct packed {
		logic [1:0] command;
		logic [4:0] start_hour;
		logic [5:0] start_minute;
		logic [4:0] end_hour;
		logic [5:0] end_minute;
		logic [6:0] weekday_mask;
		logic [3:0] delete_index;
		logic [4:0] now_hour;
		logic [5:0] now_minute;
		logic [6:0] now_day_mask;
	} alarm_cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] status;
		logic [3:0] slot;
		logic       last;
	} alarm_report_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [1:0] command = '0;
	logic [4:0] start_hour = '0;
	logic [5:0] start_minute = '0;
	logic [4:0] end_hour = '0;
	logic [5:0] end_minute = '0;
	logic [6:0] weekday_mask = '0;
	logic [3:0] delete_index = '0;
	logic [4:0] now_hour = '0;
	logic [5:0] now_minute = '0;
	logic [6:0] now_day_mask = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [1:0] kind;
	logic [1:0] status;
	logic [3:0] slot;
	logic       last;

	waet_pkg::entry_t events [TABLE_DEPTH];
	int              n_events = 0;
	alarm_report_t   owed_reports [$];
	int              tx_idle_pct = 8;
	int              rx_idle_pct = 51;
	logic            hold_rx = 1'b0;
	int              failures = 0;
	int              n_items = 0;
	int              n_reports = 0;
	int              n_on = 0;
	int              n_off = 0;
	logic [4:0]      pool_h [4];
	logic [5:0]      pool_m [4];

	weekly_alarm_event_table_top #(.TABLE_DEPTH(TABLE_DEPTH)) dut (.*);

	always #5 clk = ~clk;

	function automatic void owe(logic [1:0] k, logic [1:0] s, logic [3:0] p, logic l);
		alarm_report_t r;
		r.kind = k;
		r.status = s;
		r.slot = p;
		r.last = l;
		owed_reports.push_back(r);
	endfunction

	task automatic run_alarm_table(input alarm_cmd_t c);
		waet_pkg::entry_t e;
		case (c.command)
			waet_pkg::CMD_ADD: begin
				if (n_events >= TABLE_DEPTH) begin
					owe(waet_pkg::KIND_STATUS, waet_pkg::STAT_FULL, 4'd0, 1'b1);
				end else begin
					e.start_hour = c.start_hour;
					e.start_minute = c.start_minute;
					e.end_hour = c.end_hour;
					e.end_minute = c.end_minute;
					e.weekday_mask = c.weekday_mask;
					e.active = 1'b0;
					events[n_events] = e;
					n_events++;
					owe(waet_pkg::KIND_STATUS, waet_pkg::STAT_OK, 4'd0, 1'b1);
				end
			end
			waet_pkg::CMD_DELETE: begin
				if (n_events == 0) begin
					owe(waet_pkg::KIND_STATUS, waet_pkg::STAT_EMPTY, 4'd0, 1'b1);
				end else if (int'(c.delete_index) >= n_events) begin
					owe(waet_pkg::KIND_STATUS, waet_pkg::STAT_RANGE, 4'd0, 1'b1);
				end else begin
					for (int i = int'(c.delete_index); i < n_events - 1; i++)
						events[i] = events[i + 1];
					n_events--;
					owe(waet_pkg::KIND_STATUS, waet_pkg::STAT_OK, 4'd0, 1'b1);
				end
			end
			waet_pkg::CMD_TICK: begin
				for (int i = 0; i < n_events; i++) begin
					if (events[i].start_hour == c.now_hour && events[i].start_minute == c.now_minute
							&& (events[i].weekday_mask & c.now_day_mask) != 7'd0
							&& !events[i].active) begin
						events[i].active = 1'b1;
						owe(waet_pkg::KIND_ON, waet_pkg::STAT_OK, i[3:0], 1'b0);
					end
					if (events[i].end_hour == c.now_hour && events[i].end_minute == c.now_minute
							&& events[i].active) begin
						events[i].active = 1'b0;
						owe(waet_pkg::KIND_OFF, waet_pkg::STAT_OK, i[3:0], 1'b0);
					end
				end
				owe(waet_pkg::KIND_DONE, waet_pkg::STAT_OK, 4'd0, 1'b1);
			end
			default: ;
		endcase
	endtask

	task automatic check_report();
		alarm_report_t want;
		if (owed_reports.size() == 0) begin
			$error("result with nothing owed: kind %0d status %0d slot %0d last %0d",
				kind, status, slot, last);
			failures++;
			return;
		end
		want = owed_reports.pop_front();
		n_reports++;
		if (want.kind == waet_pkg::KIND_ON) n_on++;
		if (want.kind == waet_pkg::KIND_OFF) n_off++;
		if (kind !== want.kind) begin
			$error("kind: expected %0d, actual %0d", want.kind, kind);
			failures++;
		end
		if (status !== want.status) begin
			$error("status: expected %0d, actual %0d", want.status, status);
			failures++;
		end
		if (slot !== want.slot) begin
			$error("slot: expected %0d, actual %0d", want.slot, slot);
			failures++;
		end
		if (last !== want.last) begin
			$error("last: expected %0d, actual %0d", want.last, last);
			failures++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) check_report();
		out_stall <= hold_rx || ($urandom_range(99) < rx_idle_pct);
	end

	function automatic alarm_cmd_t junk_item();
		alarm_cmd_t c;
		c.command = 2'($urandom);
		c.start_hour = 5'($urandom);
		c.start_minute = 6'($urandom);
		c.end_hour = 5'($urandom);
		c.end_minute = 6'($urandom);
		c.weekday_mask = 7'($urandom);
		c.delete_index = 4'($urandom);
		c.now_hour = 5'($urandom);
		c.now_minute = 6'($urandom);
		c.now_day_mask = 7'($urandom);
		return c;
	endfunction

	function automatic alarm_cmd_t add_item(logic [4:0] sh, logic [5:0] sm, logic [4:0] eh,
			logic [5:0] em, logic [6:0] mask);
		alarm_cmd_t c;
		c = junk_item();
		c.command = waet_pkg::CMD_ADD;
		c.start_hour = sh;
		c.start_minute = sm;
		c.end_hour = eh;
		c.end_minute = em;
		c.weekday_mask = mask;
		return c;
	endfunction

	function automatic alarm_cmd_t del_item(logic [3:0] idx);
		alarm_cmd_t c;
		c = junk_item();
		c.command = waet_pkg::CMD_DELETE;
		c.delete_index = idx;
		return c;
	endfunction

	function automatic alarm_cmd_t tick_item(logic [4:0] h, logic [5:0] m, logic [6:0] day);
		alarm_cmd_t c;
		c = junk_item();
		c.command = waet_pkg::CMD_TICK;
		c.now_hour = h;
		c.now_minute = m;
		c.now_day_mask = day;
		return c;
	endfunction

	task automatic present(input alarm_cmd_t c);
		command <= c.command;
		start_hour <= c.start_hour;
		start_minute <= c.start_minute;
		end_hour <= c.end_hour;
		end_minute <= c.end_minute;
		weekday_mask <= c.weekday_mask;
		delete_index <= c.delete_index;
		now_hour <= c.now_hour;
		now_minute <= c.now_minute;
		now_day_mask <= c.now_day_mask;
	endtask

	task automatic send_item(input alarm_cmd_t c);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			present(junk_item());
			@(posedge clk);
		end
		in_valid <= 1'b1;
		present(c);
		do @(posedge clk); while (in_stall);
		n_items++;
		run_alarm_table(c);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (owed_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_empty_table();
		send_item(del_item(4'd0));
		send_item(tick_item(5'd0, 6'd0, 7'h7f));
		settle();
	endtask

	task automatic test_fill_to_full();
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			case (i)
				0: send_item(add_item(5'd0, 6'd0, 5'd23, 6'd59, 7'h7f));
				1: send_item(add_item(5'd23, 6'd59, 5'd0, 6'd0, 7'h01));
				2: send_item(add_item(5'd6, 6'd30, 5'd6, 6'd30, 7'h40));
				3: send_item(add_item(5'd6, 6'd30, 5'd7, 6'd15, 7'h00));
				default: send_item(add_item(5'd6, 6'd30, 5'd7, 6'd15, 7'h01 << (i % 7)));
			endcase
		end
		send_item(add_item(5'd31, 6'd63, 5'd31, 6'd63, 7'h7f));
		settle();
	endtask

	task automatic test_tick_and_delete();
		// on and off in one tick, then deletes that move active entries down
		send_item(tick_item(5'd6, 6'd30, 7'h41));
		send_item(tick_item(5'd0, 6'd0, 7'h01));
		send_item(del_item(4'd0));
		send_item(tick_item(5'd7, 6'd15, 7'h00));
		send_item(del_item(4'd15));
		send_item(del_item(4'd14));
		send_item(tick_item(5'd23, 6'd59, 7'h01));
		settle();
	endtask

	task automatic test_ignored_command();
		alarm_cmd_t c;
		c = junk_item();
		c.command = CMD_NONE;
		send_item(c);
		settle();
	endtask

	task automatic test_backpressure();
		fork
			begin
				hold_rx <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rx <= 1'b0;
			end
		join_none
		for (int i = 0; i < 24; i++) begin
			if (i % 2) send_item(tick_item(5'd7, 6'd15, 7'h7f));
			else send_item(tick_item(5'd6, 6'd30, 7'h7f));
		end
		settle();
	endtask

	task automatic test_random_traffic(input int n);
		alarm_cmd_t c;
		int sent;
		int roll;
		int w_add;
		int w_del;
		logic [1:0] a;
		logic [1:0] b;
		sent = 0;
		for (int k = 0; k < 4; k++) begin
			pool_h[k] = 5'($urandom_range(23));
			pool_m[k] = 6'($urandom_range(59));
		end
		if ($urandom_range(1)) begin
			pool_h[0] = 5'd0;
			pool_m[0] = 6'd0;
		end else begin
			pool_h[0] = 5'd23;
			pool_m[0] = 6'd59;
		end
		while (sent < n) begin
			c = junk_item();
			roll = $urandom_range(99);
			w_add = (n_events < 6) ? 55 : (n_events >= TABLE_DEPTH) ? 10 : 30;
			w_del = (n_events == 0) ? 5 : 25;
			a = 2'($urandom);
			b = 2'($urandom);
			if (roll < 3) begin
				c.command = CMD_NONE;
			end else if (roll < 3 + w_add) begin
				c.command = waet_pkg::CMD_ADD;
				if ($urandom_range(9) != 0) begin
					c.start_hour = pool_h[a];
					c.start_minute = pool_m[a];
					c.end_hour = pool_h[b];
					c.end_minute = pool_m[b];
				end
				if ($urandom_range(9) != 0) c.weekday_mask = 7'($urandom_range(127, 1));
			end else if (roll < 3 + w_add + w_del) begin
				c.command = waet_pkg::CMD_DELETE;
				if ($urandom_range(4) != 0)
					c.delete_index = 4'($urandom_range(n_events > 0 ? n_events - 1 : 0));
			end else begin
				c.command = waet_pkg::CMD_TICK;
				if ($urandom_range(9) != 0) begin
					c.now_hour = pool_h[a];
					c.now_minute = pool_m[a];
				end
				if ($urandom_range(9) < 6) c.now_day_mask = 7'h01 << $urandom_range(6);
			end
			send_item(c);
			if (c.command != CMD_NONE) sent++;
		end
		settle();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_fill_to_full();
		test_tick_and_delete();
		test_ignored_command();
		test_backpressure();
		test_random_traffic(130);
		tx_idle_pct = 51;
		rx_idle_pct = 8;
		test_random_traffic(130);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_random_traffic(130);
		$display("run covered %0d items and %0d results, %0d switch-on and %0d switch-off",
			n_items, n_reports, n_on, n_off);
		$display("with full, empty, out-of-range and ignored commands and a long output hold");
		if (failures == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
